// ===== hdl/ppas_pkg.sv =====
// Package for the priority aging scheduler: widths, codes and shared types.
// No dependencies.
package ppas_pkg;
  localparam int MaxProcs = 16;
  localparam int IdxW = $clog2(MaxProcs);
  localparam int CntW = $clog2(MaxProcs + 1);
  localparam int TimeW = 24;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    logic [TimeW:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [TimeW:0] quotient;
  } div_rsp_t;
endpackage

// ===== hdl/ppas_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on ppas_pkg.
module ppas_div (
  input  logic clk,
  input  logic rst_n,
  input  ppas_pkg::div_req_t req,
  output ppas_pkg::div_rsp_t rsp
);
  import ppas_pkg::*;
  localparam int W = TimeW + 1;

  logic [W-1:0] q_r, q_nxt;
  logic [W:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic [$clog2(W+1)-1:0] cnt_r;
  logic busy_r, done_r;
  logic [W:0] shifted;

  always_comb begin
    shifted = {rem_r[W-1:0], q_r[W-1]};
    q_nxt = {q_r[W-2:0], 1'b0};
    rem_nxt = shifted;
    if (shifted >= {{(W-15){1'b0}}, dvs_r}) begin
      rem_nxt = shifted - {{(W-15){1'b0}}, dvs_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        q_r <= req.dividend;
        rem_r <= '0;
        dvs_r <= req.divisor;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(W+1))'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = q_r;
endmodule

// ===== hdl/preemptive_priority_aging_scheduler_unit.sv =====
// Preemptive priority scheduler with aging, one time unit per schedule transaction.
// Load, clear and no-op transactions are handled in the idle state. A schedule transaction
// scans every loaded entry; arrived entries go through one shared serial divider when aging
// is on; a time jump adds a rescan. The next transaction waits for the result.
// Reset (rst_n low, synchronous) empties the table, zeroes time and counters;
// the aging divisor resets to zero. Depends on ppas_pkg and ppas_div.
module preemptive_priority_aging_scheduler_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tuser: operation[1:0]
  input  logic [1:0] in_tuser,
  // tdata: pid[7:0], arrival[23:8], burst[39:24], priority_req[47:40]
  input  logic [47:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: ran, run_pid, slot_start, switched, switch_count, finished,
  // turnaround, waiting, response, all_done[131] (lowest first)
  output logic [135:0] out_tdata,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata
);
  import ppas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DIV, S_CMP, S_JUMP, S_RUN, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] aging_r;
  logic [15:0] arr_r [MaxProcs];
  logic [15:0] bur_r [MaxProcs];
  logic [15:0] rem_r [MaxProcs];
  logic [7:0]  pri_r [MaxProcs];
  logic [7:0]  lbl_r [MaxProcs];
  logic        st_r  [MaxProcs];
  logic [TimeW-1:0] resp_r [MaxProcs];
  logic [CntW-1:0] count_r;
  logic [TimeW-1:0] time_r, sw_total_r;
  logic [7:0] last_r;
  logic last_valid_r;

  logic [CntW-1:0] i_r;
  logic [IdxW-1:0] best_r;
  logic found_r, pend_r, jumped_r;
  logic signed [TimeW+2:0] best_pr_r, eff_r;
  logic [15:0] earliest_r;
  logic [135:0] out_r;
  logic out_valid_r;

  div_req_t dreq;
  div_rsp_t drsp;
  ppas_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [IdxW-1:0] ix;
  logic signed [TimeW+2:0] wait_s;
  logic elig, pend_i;
  logic signed [TimeW+2:0] qv, eff_c;
  logic sw_c;
  logic [135:0] rpt_c;
  op_t op;

  assign op = op_t'(in_tuser);
  assign ix = i_r[IdxW-1:0];
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r;

  always_comb begin
    wait_s = $signed({3'b0, time_r}) - $signed({11'b0, arr_r[ix]})
           - ($signed({11'b0, bur_r[ix]}) - $signed({11'b0, rem_r[ix]}));
    elig = (rem_r[ix] != 16'd0) && ({8'd0, arr_r[ix]} <= time_r);
    pend_i = rem_r[ix] != 16'd0;
    dreq.start = 1'b0;
    dreq.dividend = wait_s[TimeW:0];
    dreq.divisor = aging_r;
    if (state_r == S_SCAN && i_r < count_r && elig && aging_r != 16'd0 && wait_s > 0)
      dreq.start = 1'b1;
    qv = $signed({2'b0, drsp.quotient});
    eff_c = $signed({19'b0, pri_r[ix]}) - qv;
    if (eff_c < -27'sd1000) eff_c = -27'sd1000;
  end

  always_comb begin
    sw_c = last_valid_r && last_r != lbl_r[best_r];
    rpt_c = '0;
    rpt_c[32:9] = time_r;
    if (!found_r) begin
      rpt_c[57:34] = sw_total_r;
      rpt_c[131] = 1'b1;
    end else begin
      rpt_c[0] = 1'b1;
      rpt_c[8:1] = lbl_r[best_r];
      rpt_c[33] = sw_c;
      rpt_c[57:34] = sw_total_r + TimeW'(sw_c);
      if (rem_r[best_r] == 16'd1) begin
        rpt_c[58] = 1'b1;
        rpt_c[82:59] = time_r + 1'b1 - {8'd0, arr_r[best_r]};
        rpt_c[106:83] = time_r + 1'b1 - {8'd0, arr_r[best_r]}
                      - {8'd0, bur_r[best_r]};
        rpt_c[130:107] = st_r[best_r] ? resp_r[best_r]
                       : time_r - {8'd0, arr_r[best_r]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      aging_r <= '0;
      count_r <= '0;
      time_r <= '0;
      sw_total_r <= '0;
      last_r <= '0;
      last_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) aging_r <= cfg_wdata;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            unique case (op)
              OP_LOAD: begin
                if (count_r < CntW'(MaxProcs)) begin
                  lbl_r[count_r[IdxW-1:0]] <= in_tdata[7:0];
                  arr_r[count_r[IdxW-1:0]] <= in_tdata[23:8];
                  bur_r[count_r[IdxW-1:0]] <= in_tdata[39:24];
                  rem_r[count_r[IdxW-1:0]] <= in_tdata[39:24];
                  pri_r[count_r[IdxW-1:0]] <= in_tdata[47:40];
                  st_r[count_r[IdxW-1:0]] <= 1'b0;
                  resp_r[count_r[IdxW-1:0]] <= '0;
                  count_r <= count_r + 1'b1;
                end
              end
              OP_CLEAR: begin
                count_r <= '0;
                time_r <= '0;
                sw_total_r <= '0;
                last_r <= '0;
                last_valid_r <= 1'b0;
              end
              OP_SCHED: begin
                i_r <= '0;
                found_r <= 1'b0;
                pend_r <= 1'b0;
                jumped_r <= 1'b0;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (i_r >= count_r) begin
            state_r <= (found_r || jumped_r) ? S_RUN : S_JUMP;
          end else begin
            if (pend_i && (!pend_r || arr_r[ix] < earliest_r)) begin
              pend_r <= 1'b1;
              earliest_r <= arr_r[ix];
            end
            if (!elig) begin
              i_r <= i_r + 1'b1;
            end else if (dreq.start) begin
              state_r <= S_DIV;
            end else begin
              eff_r <= $signed({19'b0, pri_r[ix]});
              state_r <= S_CMP;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            eff_r <= eff_c;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (!found_r || eff_r < best_pr_r ||
              (eff_r == best_pr_r && arr_r[ix] < arr_r[best_r])) begin
            found_r <= 1'b1;
            best_r <= ix;
            best_pr_r <= eff_r;
          end
          i_r <= i_r + 1'b1;
          state_r <= S_SCAN;
        end
        S_JUMP: begin
          jumped_r <= 1'b1;
          if (pend_r) begin
            time_r <= {8'd0, earliest_r};
            i_r <= '0;
            pend_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          out_r <= rpt_c;
          if (!found_r) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (sw_c)
              sw_total_r <= sw_total_r + 1'b1;
            if (!st_r[best_r]) begin
              st_r[best_r] <= 1'b1;
              resp_r[best_r] <= time_r - {8'd0, arr_r[best_r]};
            end
            last_r <= lbl_r[best_r];
            last_valid_r <= 1'b1;
            time_r <= time_r + 1'b1;
            rem_r[best_r] <= rem_r[best_r] - 1'b1;
            i_r <= '0;
            pend_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (i_r >= count_r) begin
            out_r[131] <= !pend_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (pend_i) pend_r <= 1'b1;
            i_r <= i_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CntW'(MaxProcs))) else $error("table overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_CMP))
    else $error("divider wait left early");
endmodule

// ===== tb/sv/preemptive_priority_aging_scheduler_unit_test.sv =====
// Self-checking test for preemptive_priority_aging_scheduler_unit: stream stimulus,
// an in-bench scheduler predictor and a result scoreboard.
// Depends on ppas_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module preemptive_priority_aging_scheduler_unit_test;
  import ppas_pkg::*;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [7:0]  pid;
    op_t         op;
  } job_cmd_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic        all_done;
    logic [23:0] response;
    logic [23:0] waiting;
    logic [23:0] turnaround;
    logic        finished;
    logic [23:0] switch_count;
    logic        switched;
    logic [23:0] slot_start;
    logic [7:0]  run_pid;
    logic        ran;
  } slot_report_t;

  typedef struct {
    job_cmd_t     cmd;
    bit           typed;
    slot_report_t report;
  } table_row_t;

  localparam int SettleCycles = 1200;
  localparam int TargetItems = 950;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [1:0] in_tuser;
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [135:0] out_tdata;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  // scheduler model state
  int unsigned job_arrival[MaxProcs];
  int unsigned job_burst[MaxProcs];
  int unsigned job_left[MaxProcs];
  int unsigned job_prio[MaxProcs];
  int unsigned job_label[MaxProcs];
  bit          job_started[MaxProcs];
  int unsigned job_resp[MaxProcs];
  int unsigned job_count;
  int unsigned now;
  int unsigned prev_label;
  bit          prev_valid;
  int unsigned switches;
  int unsigned aging_div;

  slot_report_t expected_slots[$];
  int errors;
  int sent_items;
  int slot_reports;
  int finished_jobs;
  int jumps;
  bit quiet;
  bit long_hold_done;

  preemptive_priority_aging_scheduler_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd60_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint eff_prio(int i);
    longint e;
    longint w;
    e = job_prio[i];
    if (aging_div != 0) begin
      w = longint'(now) - longint'(job_arrival[i])
          - (longint'(job_burst[i]) - longint'(job_left[i]));
      if (w > 0) e -= w / longint'(aging_div);
      if (e < -1000) e = -1000;
    end
    return e;
  endfunction

  function automatic int pick_job();
    int best;
    longint best_e;
    longint e;
    best = -1;
    best_e = 0;
    for (int i = 0; i < job_count; i++) begin
      if (job_left[i] == 0 || job_arrival[i] > now) continue;
      e = eff_prio(i);
      if (best < 0 || e < best_e || (e == best_e && job_arrival[i] < job_arrival[best])) begin
        best = i;
        best_e = e;
      end
    end
    return best;
  endfunction

  function automatic bit earliest_pending(output int unsigned t);
    bit found;
    found = 0;
    t = 0;
    for (int i = 0; i < job_count; i++)
      if (job_left[i] != 0 && (!found || job_arrival[i] < t)) begin
        t = job_arrival[i];
        found = 1;
      end
    return found;
  endfunction

  // advance the model by one transaction; returns 1 when a report is due
  function automatic bit predict_slot(job_cmd_t c, output slot_report_t r);
    int b;
    int unsigned t;
    int unsigned ta;
    bit sw;
    r = '0;
    case (c.op)
      OP_LOAD: begin
        if (job_count < MaxProcs) begin
          job_label[job_count] = c.pid;
          job_arrival[job_count] = c.arrival;
          job_burst[job_count] = c.burst;
          job_left[job_count] = c.burst;
          job_prio[job_count] = c.prio;
          job_started[job_count] = 0;
          job_resp[job_count] = 0;
          job_count++;
        end
        return 0;
      end
      OP_CLEAR: begin
        job_count = 0;
        now = 0;
        prev_label = 0;
        prev_valid = 0;
        switches = 0;
        return 0;
      end
      OP_NOP: return 0;
      default: ;
    endcase
    b = pick_job();
    if (b < 0 && earliest_pending(t)) begin
      now = t;
      jumps++;
      b = pick_job();
    end
    if (b < 0) begin
      r.slot_start = now[23:0];
      r.switch_count = switches[23:0];
      r.all_done = 1'b1;
      return 1;
    end
    t = now;
    if (!job_started[b]) begin
      job_started[b] = 1;
      job_resp[b] = (t - job_arrival[b]) & 24'hFFFFFF;
    end
    sw = prev_valid && prev_label != job_label[b];
    if (sw) switches = (switches + 1) & 24'hFFFFFF;
    prev_label = job_label[b];
    prev_valid = 1;
    now = (t + 1) & 24'hFFFFFF;
    job_left[b]--;
    r.ran = 1'b1;
    r.run_pid = job_label[b][7:0];
    r.slot_start = t[23:0];
    r.switched = sw;
    r.switch_count = switches[23:0];
    if (job_left[b] == 0) begin
      ta = (now - job_arrival[b]) & 24'hFFFFFF;
      r.finished = 1'b1;
      r.turnaround = ta[23:0];
      r.waiting = 24'(ta - job_burst[b]);
      r.response = job_resp[b][23:0];
    end
    r.all_done = !earliest_pending(t);
    return 1;
  endfunction

  task automatic send_cmd(job_cmd_t c, bit typed, slot_report_t typed_r);
    slot_report_t r;
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {c.prio, c.burst, c.arrival, c.pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (predict_slot(c, r)) expected_slots.push_back(typed ? typed_r : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send(job_cmd_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_aging(logic [15:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    aging_div = v;
  endtask

  function automatic job_cmd_t make_cmd(op_t op, logic [7:0] pid, logic [15:0] arr,
                                        logic [15:0] burst, logic [7:0] prio);
    job_cmd_t c;
    c = '0;
    c.op = op;
    c.pid = pid;
    c.arrival = arr;
    c.burst = burst;
    c.prio = prio;
    return c;
  endfunction

  function automatic job_cmd_t random_load();
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0] prio;
    arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    case ($urandom_range(0, 19))
      0: burst = 16'd0;
      1: burst = 16'($urandom);
      default: burst = 16'($urandom_range(1, 6));
    endcase
    prio = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
    return make_cmd(OP_LOAD, 8'($urandom), arr, burst, prio);
  endfunction

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result side: check, then decide the next ready
  initial begin
    slot_report_t got;
    slot_report_t exp_r;
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        slot_reports++;
        if (expected_slots.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, actual %h", $time, got);
        end else begin
          exp_r = expected_slots.pop_front();
          if (got.finished) finished_jobs++;
          check_field("ran", exp_r.ran, got.ran);
          check_field("run_pid", exp_r.run_pid, got.run_pid);
          check_field("slot_start", exp_r.slot_start, got.slot_start);
          check_field("switched", exp_r.switched, got.switched);
          check_field("switch_count", exp_r.switch_count, got.switch_count);
          check_field("finished", exp_r.finished, got.finished);
          check_field("turnaround", exp_r.turnaround, got.turnaround);
          check_field("waiting", exp_r.waiting, got.waiting);
          check_field("response", exp_r.response, got.response);
          check_field("all_done", exp_r.all_done, got.all_done);
        end
      end
      if (!long_hold_done && sent_items >= 300) begin
        long_hold_done = 1;
        stall_left = 6000;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    table_row_t rows[$];
    slot_report_t r;
    logic [15:0] div_choices[6];
    int n;
    errors = 0;
    sent_items = 0;
    slot_reports = 0;
    finished_jobs = 0;
    jumps = 0;
    quiet = 0;
    long_hold_done = 0;
    job_count = 0;
    now = 0;
    prev_label = 0;
    prev_valid = 0;
    switches = 0;
    aging_div = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = '0; r.all_done = 1'b1;
    rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b1, r});
    rows.push_back('{make_cmd(OP_NOP, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0});
    rows.push_back('{make_cmd(OP_LOAD, 8'hFF, 16'h0000, 16'h0002, 8'hFF), 1'b0, '0});
    rows.push_back('{make_cmd(OP_LOAD, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b0, '0});
    r = '0; r.ran = 1'b1; r.run_pid = 8'hFF;
    rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b1, r});
    r = '0; r.ran = 1'b1; r.run_pid = 8'hFF; r.slot_start = 24'd1; r.finished = 1'b1;
    r.turnaround = 24'd2; r.all_done = 1'b1;
    rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b1, r});
    r = '0; r.slot_start = 24'd2; r.all_done = 1'b1;
    rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b1, r});
    rows.push_back('{make_cmd(OP_LOAD, 8'h5A, 16'hFFFF, 16'h0001, 8'h00), 1'b0, '0});
    rows.push_back('{make_cmd(OP_LOAD, 8'hA5, 16'h0064, 16'hFFFF, 8'h80), 1'b0, '0});
    rows.push_back('{make_cmd(OP_LOAD, 8'h3C, 16'h0064, 16'h0002, 8'h80), 1'b0, '0});
    for (int i = 0; i < 4; i++)
      rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b0, '0});
    rows.push_back('{make_cmd(OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b0, '0});
    r = '0; r.all_done = 1'b1;
    rows.push_back('{make_cmd(OP_SCHED, 8'h00, 16'h0000, 16'h0000, 8'h00), 1'b1, r});
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].report);

    div_choices = '{16'd1, 16'd65535, 16'd2, 16'd0, 16'd3, 16'd7};
    n = 0;
    while (sent_items < TargetItems) begin
      set_aging((n < 6) ? div_choices[n] : 16'($urandom_range(0, 5) == 0 ? $urandom
                                                                     : $urandom_range(0, 8)));
      n++;
      if (sent_items > TargetItems - 100) quiet = 1;
      send(make_cmd(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
      repeat ($urandom_range(1, 18)) send(random_load());
      repeat ($urandom_range(1, 40)) begin
        case ($urandom_range(0, 19))
          0: send(random_load());
          1: send(make_cmd(OP_NOP, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
          default: send(make_cmd(OP_SCHED, 8'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom)));
        endcase
      end
    end
    settle();
    $display("Covered %0d transactions over %0d aging settings: %0d slot reports,",
             sent_items, n + 1, slot_reports);
    $display("%0d job completions, %0d idle-time jumps.", finished_jobs, jumps);
    if (errors == 0 && expected_slots.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
